[rtl/core/lspp_pkg.sv]
package lspp_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_HEADER,
    PH_SAMPLES
  } phase_t;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [2:0] HDR_LAST    = 3'd7;

  localparam logic [2:0] HDR_TYPE      = 3'd0;
  localparam logic [2:0] HDR_COUNT     = 3'd1;
  localparam logic [2:0] HDR_START_LO  = 3'd2;
  localparam logic [2:0] HDR_START_HI  = 3'd3;
  localparam logic [2:0] HDR_END_LO    = 3'd4;
  localparam logic [2:0] HDR_END_HI    = 3'd5;
  localparam logic [2:0] HDR_CHECK_LO  = 3'd6;
  localparam logic [2:0] HDR_CHECK_HI  = 3'd7;

  typedef struct packed {
    logic [15:0] distance_q2;
    logic [7:0]  sample_index;
    logic [7:0]  packet_type;
    logic [7:0]  sample_count;
    logic [15:0] start_angle;
    logic [15:0] end_angle;
    logic [15:0] check_word;
    logic        last;
  } result_t;

endpackage

[rtl/core/lidar_scan_packet_parser_top.sv]
// A result passes from the byte that completes its sample through the input
// register, then parse logic, into the result register.
// Throughput: one byte per cycle while the result register is free or read out;
// while a result waits, the input register can still take one byte.
// Reset: synchronous rst returns the parser to sync hunting, holds cleared.
module lidar_scan_packet_parser_top
  import lspp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] distance_q2,
  output logic [7:0]  sample_index,
  output logic [7:0]  packet_type,
  output logic [7:0]  sample_count,
  output logic [15:0] start_angle,
  output logic [15:0] end_angle,
  output logic [15:0] check_word,
  output logic        last
);

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       byte_take;
  logic       out_free;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  lspp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take)
  );

  lspp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .out_free   (out_free),
    .byte_take  (byte_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  lspp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign distance_q2  = out_res.distance_q2;
  assign sample_index = out_res.sample_index;
  assign packet_type  = out_res.packet_type;
  assign sample_count = out_res.sample_count;
  assign start_angle  = out_res.start_angle;
  assign end_angle    = out_res.end_angle;
  assign check_word   = out_res.check_word;
  assign last         = out_res.last;

endmodule

[rtl/core/lspp_in_reg.sv]
module lspp_in_reg
  import lspp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       byte_valid,
  output logic [7:0] byte_data,
  input  logic       byte_take
);

  logic       full;
  logic [7:0] data;

  assign in_ready   = !full || byte_take;
  assign byte_valid = full;
  assign byte_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= rx_byte;
    end
  end

endmodule

[rtl/core/lspp_parser.sv]
module lspp_parser
  import lspp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  input  logic       out_free,
  output logic       byte_take,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [2:0]  header_pos, header_pos_next;
  logic [7:0]  type_hold, type_hold_next;
  logic [7:0]  count_hold, count_hold_next;
  logic [15:0] start_hold, start_hold_next;
  logic [15:0] end_hold, end_hold_next;
  logic [15:0] check_hold, check_hold_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic        byte_phase, byte_phase_next;
  logic [7:0]  samples_done, samples_done_next;
  logic        is_last;

  assign byte_take = byte_valid && out_free;
  assign is_last   = ({1'b0, samples_done} + 9'd1) >= {1'b0, count_hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      header_pos    <= '0;
      type_hold     <= '0;
      count_hold    <= '0;
      start_hold    <= '0;
      end_hold      <= '0;
      check_hold    <= '0;
      low_byte_hold <= '0;
      byte_phase    <= 1'b0;
      samples_done  <= '0;
    end else if (byte_take) begin
      phase         <= phase_next;
      header_pos    <= header_pos_next;
      type_hold     <= type_hold_next;
      count_hold    <= count_hold_next;
      start_hold    <= start_hold_next;
      end_hold      <= end_hold_next;
      check_hold    <= check_hold_next;
      low_byte_hold <= low_byte_hold_next;
      byte_phase    <= byte_phase_next;
      samples_done  <= samples_done_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    header_pos_next    = header_pos;
    type_hold_next     = type_hold;
    count_hold_next    = count_hold;
    start_hold_next    = start_hold;
    end_hold_next      = end_hold;
    check_hold_next    = check_hold;
    low_byte_hold_next = low_byte_hold;
    byte_phase_next    = byte_phase;
    samples_done_next  = samples_done;
    res_valid          = 1'b0;

    res.distance_q2  = {byte_data, low_byte_hold};
    res.sample_index = samples_done;
    res.packet_type  = type_hold;
    res.sample_count = count_hold;
    res.start_angle  = start_hold;
    res.end_angle    = end_hold;
    res.check_word   = check_hold;
    res.last         = is_last;

    unique case (phase)
      PH_HUNT: begin
        if (byte_data == SYNC_FIRST) begin
          phase_next = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (byte_data == SYNC_SECOND) begin
          phase_next      = PH_HEADER;
          header_pos_next = '0;
        end else if (byte_data != SYNC_FIRST) begin
          phase_next = PH_HUNT;
        end
      end
      PH_HEADER: begin
        unique case (header_pos)
          HDR_TYPE:     type_hold_next  = byte_data;
          HDR_COUNT:    count_hold_next = byte_data;
          HDR_START_LO: start_hold_next = {start_hold[15:8], byte_data};
          HDR_START_HI: start_hold_next = {byte_data, start_hold[7:0]};
          HDR_END_LO:   end_hold_next   = {end_hold[15:8], byte_data};
          HDR_END_HI:   end_hold_next   = {byte_data, end_hold[7:0]};
          HDR_CHECK_LO: check_hold_next = {check_hold[15:8], byte_data};
          HDR_CHECK_HI: check_hold_next = {byte_data, check_hold[7:0]};
          default:      check_hold_next = check_hold;
        endcase
        if (header_pos == HDR_LAST) begin
          header_pos_next   = '0;
          byte_phase_next   = 1'b0;
          samples_done_next = '0;
          phase_next        = (count_hold == 8'd0) ? PH_HUNT : PH_SAMPLES;
        end else begin
          header_pos_next = header_pos + 3'd1;
        end
      end
      PH_SAMPLES: begin
        if (!byte_phase) begin
          low_byte_hold_next = byte_data;
          byte_phase_next    = 1'b1;
        end else begin
          res_valid       = byte_take;
          byte_phase_next = 1'b0;
          if (is_last) begin
            phase_next        = PH_HUNT;
            header_pos_next   = '0;
            samples_done_next = '0;
          end else begin
            samples_done_next = samples_done + 8'd1;
          end
        end
      end
      default: phase_next = PH_HUNT;
    endcase
  end

endmodule

[rtl/core/lspp_out_reg.sv]
module lspp_out_reg
  import lspp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid;
  result_t data;

  assign out_free  = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      data <= res;
    end
  end

endmodule

[dv/lidar_scan_packet_parser_checker.sv]
module lidar_scan_packet_parser_checker
  import lspp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] distance_q2,
  input  logic [7:0]  sample_index,
  input  logic [7:0]  packet_type,
  input  logic [7:0]  sample_count,
  input  logic [15:0] start_angle,
  input  logic [15:0] end_angle,
  input  logic [15:0] check_word,
  input  logic        last,
  output int          mismatches,
  output int          samples_pending,
  output int          samples_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t      parse_phase;
  logic [2:0]  hdr_pos;
  logic [7:0]  type_q;
  logic [7:0]  count_q;
  logic [7:0]  low_q;
  logic [7:0]  done_q;
  logic [15:0] start_q;
  logic [15:0] end_q;
  logic [15:0] check_q;
  logic        want_high;
  result_t     expected_samples [$];

  task automatic return_to_hunt();
    parse_phase = PH_HUNT;
    hdr_pos     = '0;
    want_high   = 1'b0;
    done_q      = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    result_t r;
    case (parse_phase)
      PH_HUNT: begin
        if (b == SYNC_FIRST) parse_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          parse_phase = PH_HEADER;
          hdr_pos     = '0;
        end else if (b != SYNC_FIRST) begin
          parse_phase = PH_HUNT;
        end
      end
      PH_HEADER: begin
        case (hdr_pos)
          HDR_TYPE:     type_q        = b;
          HDR_COUNT:    count_q       = b;
          HDR_START_LO: start_q[7:0]  = b;
          HDR_START_HI: start_q[15:8] = b;
          HDR_END_LO:   end_q[7:0]    = b;
          HDR_END_HI:   end_q[15:8]   = b;
          HDR_CHECK_LO: check_q[7:0]  = b;
          default:      check_q[15:8] = b;
        endcase
        if (hdr_pos == HDR_LAST) begin
          hdr_pos   = '0;
          want_high = 1'b0;
          done_q    = '0;
          if (count_q == 8'd0) return_to_hunt();
          else parse_phase = PH_SAMPLES;
        end else begin
          hdr_pos = hdr_pos + 3'd1;
        end
      end
      default: begin
        if (!want_high) begin
          low_q     = b;
          want_high = 1'b1;
        end else begin
          r.distance_q2  = {b, low_q};
          r.sample_index = done_q;
          r.packet_type  = type_q;
          r.sample_count = count_q;
          r.start_angle  = start_q;
          r.end_angle    = end_q;
          r.check_word   = check_q;
          r.last         = ({1'b0, done_q} + 9'd1) >= {1'b0, count_q};
          expected_samples.push_back(r);
          want_high = 1'b0;
          if (r.last) return_to_hunt();
          else done_q = done_q + 8'd1;
        end
      end
    endcase
  endtask

  function automatic string show(input result_t r);
    return $sformatf("dist=%h idx=%0d type=%h count=%0d start=%h end=%h check=%h last=%b",
                     r.distance_q2, r.sample_index, r.packet_type, r.sample_count,
                     r.start_angle, r.end_angle, r.check_word, r.last);
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      type_q  = '0;
      count_q = '0;
      start_q = '0;
      end_q   = '0;
      check_q = '0;
      low_q   = '0;
      return_to_hunt();
      expected_samples.delete();
    end else begin
      if (in_valid && in_ready) parse_byte(rx_byte);
      if (out_valid && out_ready) begin
        seen = {distance_q2, sample_index, packet_type, sample_count,
                start_angle, end_angle, check_word, last};
        samples_checked++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected sample: %s", show(seen));
        end else begin
          want = expected_samples.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("sample mismatch at %0t", $realtime);
              $display("  exp %s", show(want));
              $display("  got %s", show(seen));
            end
          end
        end
      end
    end
    samples_pending <= expected_samples.size();
  end

endmodule

[dv/lidar_scan_packet_parser_top_tb.sv]
module lidar_scan_packet_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lspp_pkg::*;

  localparam int BYTE_TARGET     = 1550;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STUCK_LIMIT     = 3000;

  // bad sync, repeated sync with empty packet, sync values inside header and extreme samples
  localparam logic [7:0] OPENING_BYTES [27] = '{
    8'hAA, 8'h3C,
    8'hAA, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h34, 8'h12, 8'h78, 8'h56, 8'hBC, 8'h9A,
    8'hAA, 8'h55, 8'hAA, 8'h02, 8'h55, 8'hAA, 8'hFF, 8'hFF, 8'h00, 8'h00,
    8'h00, 8'h00, 8'hFF, 8'hFF
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_ready = 1'b0;
  logic        jitter_on = 1'b1;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] distance_q2;
  logic [7:0]  sample_index;
  logic [7:0]  packet_type;
  logic [7:0]  sample_count;
  logic [15:0] start_angle;
  logic [15:0] end_angle;
  logic [15:0] check_word;
  logic        last;

  int mismatches;
  int samples_pending;
  int samples_checked;
  int bytes_sent;
  int packets_sent;
  int empty_packets;
  int hold_requests;
  int holds_served;
  int stuck_cycles;

  lidar_scan_packet_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance_q2  (distance_q2),
    .sample_index (sample_index),
    .packet_type  (packet_type),
    .sample_count (sample_count),
    .start_angle  (start_angle),
    .end_angle    (end_angle),
    .check_word   (check_word),
    .last         (last)
  );

  lidar_scan_packet_parser_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .distance_q2     (distance_q2),
    .sample_index    (sample_index),
    .packet_type     (packet_type),
    .sample_count    (sample_count),
    .start_angle     (start_angle),
    .end_angle       (end_angle),
    .check_word      (check_word),
    .last            (last),
    .mismatches      (mismatches),
    .samples_pending (samples_pending),
    .samples_checked (samples_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    while (jitter_on && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] data_byte(input bit sync_heavy);
    if (sync_heavy) return $urandom_range(1) ? SYNC_FIRST : SYNC_SECOND;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_packet(input logic [7:0] count, input bit sync_heavy);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (int i = 0; i < 8; i++) send_byte(i == 1 ? count : data_byte(sync_heavy));
    repeat (2 * count) send_byte(data_byte(sync_heavy));
    packets_sent++;
    if (count == 8'd0) empty_packets++;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        holds_served++;
      end
      out_ready <= !(jitter_on && $urandom_range(99) < 27);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d samples outstanding",
               stuck_cycles, samples_pending);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int kind;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
    while (bytes_sent < BYTE_TARGET) begin
      jitter_on <= !(packets_sent >= 30 && packets_sent < 45);
      if (packets_sent == 10 && hold_requests == 0) hold_requests <= hold_requests + 1;
      kind = $urandom_range(99);
      if (packets_sent == 20) begin
        send_packet(8'd255, 1'b0);
      end else if (kind < 60) begin
        send_packet(8'($urandom_range(1, 6)), 1'b0);
      end else if (kind < 68) begin
        send_packet(8'($urandom_range(7, 40)), 1'b0);
      end else if (kind < 72) begin
        send_packet(8'd0, 1'b0);
      end else if (kind < 80) begin
        send_packet(8'($urandom_range(1, 4)), 1'b1);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(data_byte(1'b0));
      end else begin
        // repeated first sync, then either a bad second byte or a cut-short header
        repeat ($urandom_range(1, 3)) send_byte(SYNC_FIRST);
        if ($urandom_range(1)) begin
          send_byte(data_byte(1'b0));
        end else begin
          send_byte(SYNC_SECOND);
          repeat ($urandom_range(0, 7)) send_byte(data_byte(1'b0));
        end
      end
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (samples_pending != 0);
    repeat (8) @(posedge clk);
    $display("Streamed %0d bytes: %0d framed packets (%0d empty), %0d samples compared",
             bytes_sent, packets_sent, empty_packets, samples_checked);
    $display("Included a %0d-cycle output hold-off and a 255-sample packet",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lspp_pkg.sv
rtl/core/lspp_in_reg.sv
rtl/core/lspp_parser.sv
rtl/core/lspp_out_reg.sv
rtl/core/lidar_scan_packet_parser_top.sv
dv/lidar_scan_packet_parser_checker.sv
dv/lidar_scan_packet_parser_top_tb.sv
